// ===== design/i2csb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2csb_pkg
// Shared types and phase codes for the I2C sensor bus master.
// ----------------------------------------------------------------------------
package i2csb_pkg;

  localparam logic [6:0] DEV_ADDR_RESET = 7'h23;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START     = 5'd1;
  localparam logic [4:0] PH_TX_LOW    = 5'd2;
  localparam logic [4:0] PH_TX_HIGH   = 5'd3;
  localparam logic [4:0] PH_ACK_LOW   = 5'd4;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd5;
  localparam logic [4:0] PH_RX_LOW    = 5'd6;
  localparam logic [4:0] PH_RX_HIGH   = 5'd7;
  localparam logic [4:0] PH_MACK_LOW  = 5'd8;
  localparam logic [4:0] PH_MACK_HIGH = 5'd9;
  localparam logic [4:0] PH_STOP_LOW  = 5'd10;
  localparam logic [4:0] PH_STOP_HIGH = 5'd11;
  localparam logic [4:0] PH_STOP_END  = 5'd12;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic       go;
    logic       op;
    logic [7:0] command;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        busy_res;
    logic        done_res;
    logic [15:0] reading;
    logic        nak_seen;
  } out_t;

  typedef struct packed {
    logic [4:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [1:0]  byte_index;
    logic        kind;
    logic [7:0]  command_latch;
    logic [15:0] reading_reg;
    logic        nak_flag;
  } state_t;

endpackage
`default_nettype wire

// ===== design/i2c_sensor_bus_master.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_sensor_bus_master
// I2C master for a two-byte sensor: command writes and measurement reads.
// ----------------------------------------------------------------------------
// usage
//   each input transaction on in_valid/in_ready is one half-bit tick of the
//   bus; it carries go, op, command and the sampled sda_in level
//   each tick yields exactly one output transaction on out_valid/out_ready
//   with the scl/sda drive levels, busy/done flags, last reading and nak flag
//   a write is start, address+w, command, stop; a read is start, address+r,
//   two received bytes (ack then nak), stop
//   out_valid rises in the cycle after a tick is accepted; the tick's logic sits
//   between the port and the result register, so one tick per cycle is
//   taken as long as the result register is empty or being drained
//   stall: when out_ready is low with a result pending, in_ready drops and
//   the bus state holds until the result is taken
//   reset (rst, synchronous): phase idle, all state cleared, device address
//   back to 0x23, no result pending
//   cfg_we/cfg_data load the 7-bit device address at the end of a cfg_we cycle
// ----------------------------------------------------------------------------
module i2c_sensor_bus_master (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire i2csb_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output i2csb_pkg::out_t      out_data,
  input  wire logic            cfg_we,
  input  wire logic [6:0]      cfg_data
);

  // bus state and configuration
  i2csb_pkg::state_t st;
  i2csb_pkg::state_t st_next;
  i2csb_pkg::out_t   res_next;
  logic [6:0]        device_address;
  logic              accept;

  // result slot frees up when empty or drained this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  i2csb_step u_step (
    .device_address (device_address),
    .cur            (st),
    .item           (in_data),
    .nxt            (st_next),
    .result         (res_next)
  );

  // control state (phase, counters, flags), result valid flag and device address; all-zero state is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= '0;
      out_valid      <= 1'b0;
      device_address <= i2csb_pkg::DEV_ADDR_RESET;
    end else begin
      if (cfg_we) begin
        device_address <= cfg_data;
      end
      if (accept) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded on every accepted tick
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/i2csb_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2csb_step
// Next-state and line-level logic for one half-bit tick of the bus master.
// ----------------------------------------------------------------------------
module i2csb_step (
  input  wire logic [6:0]       device_address,
  input  wire i2csb_pkg::state_t cur,
  input  wire i2csb_pkg::in_t    item,
  output i2csb_pkg::state_t      nxt,
  output i2csb_pkg::out_t        result
);

  logic [4:0] ph;
  logic [3:0] bc_inc;
  logic       scl;
  logic       sda;
  logic       busy;
  logic       done;

  assign bc_inc = cur.bit_count + 4'd1;

  always_comb begin
    nxt  = cur;
    ph   = cur.phase;
    scl  = 1'b1;
    sda  = 1'b1;
    busy = 1'b1;
    done = 1'b0;

    // meaningless phase codes behave as idle
    if (ph > i2csb_pkg::PH_STOP_END) begin
      ph = i2csb_pkg::PH_IDLE;
    end
    if (ph == i2csb_pkg::PH_IDLE && item.go) begin
      nxt.kind          = item.op;
      nxt.command_latch = item.command;
      nxt.nak_flag      = 1'b0;
      ph                = i2csb_pkg::PH_START;
    end

    unique case (ph)
      i2csb_pkg::PH_START: begin
        sda            = 1'b0;
        nxt.shift_byte = {device_address, nxt.kind};
        nxt.bit_count  = 4'd0;
        nxt.byte_index = 2'd0;
        nxt.phase      = i2csb_pkg::PH_TX_LOW;
      end
      i2csb_pkg::PH_TX_LOW: begin
        scl       = 1'b0;
        sda       = cur.shift_byte[7];
        nxt.phase = i2csb_pkg::PH_TX_HIGH;
      end
      i2csb_pkg::PH_TX_HIGH: begin
        sda            = cur.shift_byte[7];
        nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
        nxt.bit_count  = bc_inc;
        nxt.phase      = (bc_inc >= i2csb_pkg::BITS_PER_BYTE) ?
                         i2csb_pkg::PH_ACK_LOW : i2csb_pkg::PH_TX_LOW;
      end
      i2csb_pkg::PH_ACK_LOW: begin
        scl       = 1'b0;
        nxt.phase = i2csb_pkg::PH_ACK_HIGH;
      end
      i2csb_pkg::PH_ACK_HIGH: begin
        if (item.sda_in) begin
          nxt.nak_flag = 1'b1;
        end
        nxt.bit_count = 4'd0;
        if (cur.byte_index == 2'd0 && cur.kind == i2csb_pkg::OP_WRITE) begin
          nxt.shift_byte = cur.command_latch;
          nxt.byte_index = 2'd1;
          nxt.phase      = i2csb_pkg::PH_TX_LOW;
        end else if (cur.byte_index == 2'd0) begin
          nxt.shift_byte = 8'd0;
          nxt.phase      = i2csb_pkg::PH_RX_LOW;
        end else begin
          nxt.phase = i2csb_pkg::PH_STOP_LOW;
        end
      end
      i2csb_pkg::PH_RX_LOW: begin
        scl       = 1'b0;
        nxt.phase = i2csb_pkg::PH_RX_HIGH;
      end
      i2csb_pkg::PH_RX_HIGH: begin
        nxt.shift_byte = {cur.shift_byte[6:0], item.sda_in};
        nxt.bit_count  = bc_inc;
        nxt.phase      = (bc_inc >= i2csb_pkg::BITS_PER_BYTE) ?
                         i2csb_pkg::PH_MACK_LOW : i2csb_pkg::PH_RX_LOW;
      end
      i2csb_pkg::PH_MACK_LOW: begin
        scl       = 1'b0;
        sda       = (cur.byte_index != 2'd0);
        nxt.phase = i2csb_pkg::PH_MACK_HIGH;
      end
      i2csb_pkg::PH_MACK_HIGH: begin
        sda = (cur.byte_index != 2'd0);
        if (cur.byte_index == 2'd0) begin
          nxt.command_latch = cur.shift_byte;
          nxt.shift_byte    = 8'd0;
          nxt.bit_count     = 4'd0;
          nxt.byte_index    = 2'd1;
          nxt.phase         = i2csb_pkg::PH_RX_LOW;
        end else begin
          nxt.phase = i2csb_pkg::PH_STOP_LOW;
        end
      end
      i2csb_pkg::PH_STOP_LOW: begin
        scl       = 1'b0;
        sda       = 1'b0;
        nxt.phase = i2csb_pkg::PH_STOP_HIGH;
      end
      i2csb_pkg::PH_STOP_HIGH: begin
        sda       = 1'b0;
        nxt.phase = i2csb_pkg::PH_STOP_END;
      end
      i2csb_pkg::PH_STOP_END: begin
        busy = 1'b0;
        done = 1'b1;
        if (cur.kind == i2csb_pkg::OP_READ) begin
          nxt.reading_reg = {cur.command_latch, cur.shift_byte};
        end
        nxt.phase = i2csb_pkg::PH_IDLE;
      end
      default: begin
        busy      = 1'b0;
        nxt.phase = i2csb_pkg::PH_IDLE;
      end
    endcase
  end

  assign result.scl      = scl;
  assign result.sda_out  = sda;
  assign result.busy_res = busy;
  assign result.done_res = done;
  assign result.reading  = nxt.reading_reg;
  assign result.nak_seen = nxt.nak_flag;

endmodule
`default_nettype wire

// ===== tb/tb_i2c_sensor_bus_master.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_sensor_bus_master
// Drives the I2C master one half-bit tick per input transaction, tracks the
// bus state alongside it and compares every output transaction field by field.
// ----------------------------------------------------------------------------

// tracks the master's bus state and holds the tick outputs still to arrive
class bus_tick_scoreboard;
  logic [6:0]       dev_addr;
  logic [4:0]       phase;
  logic [3:0]       bit_cnt;
  logic [7:0]       shreg;
  logic [1:0]       byte_idx;
  logic             kind;
  logic [7:0]       cmd_latch;
  logic [15:0]      last_reading;
  logic             nak;
  i2csb_pkg::out_t  expected_ticks[$];
  int unsigned      faults;
  int unsigned      ticks_checked;

  function new();
    dev_addr     = i2csb_pkg::DEV_ADDR_RESET;
    phase        = i2csb_pkg::PH_IDLE;
    bit_cnt      = '0;
    shreg        = '0;
    byte_idx     = '0;
    kind         = i2csb_pkg::OP_WRITE;
    cmd_latch    = '0;
    last_reading = '0;
    nak          = 1'b0;
    faults       = 0;
    ticks_checked = 0;
  endfunction

  function void set_address(logic [6:0] addr);
    dev_addr = addr;
  endfunction

  // advance the bus by one tick and queue the levels it should produce
  function void note_tick(i2csb_pkg::in_t t);
    i2csb_pkg::out_t e;
    logic [4:0]      cur;
    e = '0;
    e.scl      = 1'b1;
    e.sda_out  = 1'b1;
    e.busy_res = 1'b1;
    e.done_res = 1'b0;
    cur = (phase > i2csb_pkg::PH_STOP_END) ? i2csb_pkg::PH_IDLE : phase;
    if (cur == i2csb_pkg::PH_IDLE && t.go) begin
      kind      = t.op;
      cmd_latch = t.command;
      nak       = 1'b0;
      cur       = i2csb_pkg::PH_START;
    end
    case (cur)
      i2csb_pkg::PH_START: begin
        e.sda_out = 1'b0;
        shreg     = {dev_addr, kind};
        bit_cnt   = '0;
        byte_idx  = '0;
        phase     = i2csb_pkg::PH_TX_LOW;
      end
      i2csb_pkg::PH_TX_LOW: begin
        e.scl     = 1'b0;
        e.sda_out = shreg[7];
        phase     = i2csb_pkg::PH_TX_HIGH;
      end
      i2csb_pkg::PH_TX_HIGH: begin
        e.sda_out = shreg[7];
        shreg     = {shreg[6:0], 1'b0};
        bit_cnt   = bit_cnt + 4'd1;
        phase     = (bit_cnt >= i2csb_pkg::BITS_PER_BYTE) ?
                    i2csb_pkg::PH_ACK_LOW : i2csb_pkg::PH_TX_LOW;
      end
      i2csb_pkg::PH_ACK_LOW: begin
        e.scl = 1'b0;
        phase = i2csb_pkg::PH_ACK_HIGH;
      end
      i2csb_pkg::PH_ACK_HIGH: begin
        if (t.sda_in) nak = 1'b1;
        bit_cnt = '0;
        if (byte_idx == 2'd0 && kind == i2csb_pkg::OP_WRITE) begin
          shreg    = cmd_latch;
          byte_idx = 2'd1;
          phase    = i2csb_pkg::PH_TX_LOW;
        end else if (byte_idx == 2'd0) begin
          shreg = '0;
          phase = i2csb_pkg::PH_RX_LOW;
        end else begin
          phase = i2csb_pkg::PH_STOP_LOW;
        end
      end
      i2csb_pkg::PH_RX_LOW: begin
        e.scl = 1'b0;
        phase = i2csb_pkg::PH_RX_HIGH;
      end
      i2csb_pkg::PH_RX_HIGH: begin
        shreg   = {shreg[6:0], t.sda_in};
        bit_cnt = bit_cnt + 4'd1;
        phase   = (bit_cnt >= i2csb_pkg::BITS_PER_BYTE) ?
                  i2csb_pkg::PH_MACK_LOW : i2csb_pkg::PH_RX_LOW;
      end
      i2csb_pkg::PH_MACK_LOW: begin
        e.scl     = 1'b0;
        e.sda_out = (byte_idx != 2'd0);
        phase     = i2csb_pkg::PH_MACK_HIGH;
      end
      i2csb_pkg::PH_MACK_HIGH: begin
        e.sda_out = (byte_idx != 2'd0);
        if (byte_idx == 2'd0) begin
          cmd_latch = shreg;
          shreg     = '0;
          bit_cnt   = '0;
          byte_idx  = 2'd1;
          phase     = i2csb_pkg::PH_RX_LOW;
        end else begin
          phase = i2csb_pkg::PH_STOP_LOW;
        end
      end
      i2csb_pkg::PH_STOP_LOW: begin
        e.scl     = 1'b0;
        e.sda_out = 1'b0;
        phase     = i2csb_pkg::PH_STOP_HIGH;
      end
      i2csb_pkg::PH_STOP_HIGH: begin
        e.sda_out = 1'b0;
        phase     = i2csb_pkg::PH_STOP_END;
      end
      i2csb_pkg::PH_STOP_END: begin
        e.busy_res = 1'b0;
        e.done_res = 1'b1;
        if (kind == i2csb_pkg::OP_READ) last_reading = {cmd_latch, shreg};
        phase = i2csb_pkg::PH_IDLE;
      end
      default: begin
        e.busy_res = 1'b0;
        phase      = i2csb_pkg::PH_IDLE;
      end
    endcase
    e.reading  = last_reading;
    e.nak_seen = nak;
    expected_ticks.push_back(e);
  endfunction

  function void flag(string what, logic [15:0] exp, logic [15:0] got);
    faults++;
    if (faults <= 10)
      $display("mismatch on %s at tick %0d: expected %0h, got %0h",
               what, ticks_checked, exp, got);
  endfunction

  function void check_tick(i2csb_pkg::out_t got);
    i2csb_pkg::out_t e;
    if (expected_ticks.size() == 0) begin
      faults++;
      if (faults <= 10) $display("output transaction with nothing pending: %p", got);
      return;
    end
    e = expected_ticks.pop_front();
    if (got.scl !== e.scl)           flag("scl", 16'(e.scl), 16'(got.scl));
    if (got.sda_out !== e.sda_out)   flag("sda_out", 16'(e.sda_out), 16'(got.sda_out));
    if (got.busy_res !== e.busy_res) flag("busy_res", 16'(e.busy_res), 16'(got.busy_res));
    if (got.done_res !== e.done_res) flag("done_res", 16'(e.done_res), 16'(got.done_res));
    if (got.reading !== e.reading)   flag("reading", e.reading, got.reading);
    if (got.nak_seen !== e.nak_seen) flag("nak_seen", 16'(e.nak_seen), 16'(got.nak_seen));
    ticks_checked++;
  endfunction
endclass

module tb_i2c_sensor_bus_master;

  // how the fake slave drives the data line during a transaction
  typedef enum int {SDA_ACKING, SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_t;

  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up
  localparam int SEGMENT_TICKS  = 430;   // random ticks per idling setting

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  i2csb_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  i2csb_pkg::out_t out_data;
  logic            cfg_we;
  logic [6:0]      cfg_data;

  bus_tick_scoreboard tracker;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned ticks_sent;
  int unsigned quiet_cycles = 0;
  bit          hold_req;

  i2c_sensor_bus_master u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one tick at the falling edge, with random gaps before it, and hold
  // it until the rising edge that accepts the transaction
  task automatic send_tick(input i2csb_pkg::in_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_tick(t);
    ticks_sent++;
  endtask

  // stop offering and wait until every tick output has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_ticks.size() != 0) @(posedge clk);
  endtask

  // address writes only happen with nothing in flight and the bus idle
  task automatic write_address(input logic [6:0] addr);
    drain();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = addr;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_address(addr);
  endtask

  // one full bus transaction from the go tick back to idle; go_noise_pct
  // raises go on busy ticks, including the tick where stop finishes
  task automatic run_transfer(input logic op, input logic [7:0] cmd,
                              input sda_mode_t mode, input int go_noise_pct);
    i2csb_pkg::in_t t;
    t         = '0;
    t.go      = 1'b1;
    t.op      = op;
    t.command = cmd;
    t.sda_in  = 1'($urandom_range(1));
    send_tick(t);
    do begin
      t.go      = ($urandom_range(99) < go_noise_pct);
      t.op      = 1'($urandom_range(1));
      t.command = 8'($urandom_range(255));
      case (mode)
        SDA_LOW:  t.sda_in = 1'b0;
        SDA_HIGH: t.sda_in = 1'b1;
        // a well-behaved slave acks low, with a rare missing ack
        SDA_ACKING: begin
          if (tracker.phase == i2csb_pkg::PH_ACK_HIGH)
            t.sda_in = ($urandom_range(99) < 5);
          else t.sda_in = 1'($urandom_range(1));
        end
        default: t.sda_in = 1'($urandom_range(1));
      endcase
      send_tick(t);
    end while (tracker.phase != i2csb_pkg::PH_IDLE);
  endtask

  // random transactions under one idling setting, ending with a full pause
  task automatic random_segment(input int unsigned s_pct, input int unsigned r_pct,
                                input bit with_hold);
    i2csb_pkg::in_t idle_t;
    int unsigned    target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_address(7'($urandom_range(127)));
    target = ticks_sent + SEGMENT_TICKS;
    if (with_hold) hold_req = 1'b1;
    while (ticks_sent < target) begin
      if ($urandom_range(99) < 75)
        run_transfer(1'($urandom_range(1)), 8'($urandom_range(255)), SDA_ACKING,
                     int'($urandom_range(5)));
      else
        run_transfer(1'($urandom_range(1)), 8'($urandom_range(255)),
                     sda_mode_t'($urandom_range(3)), int'($urandom_range(60)));
      // idle ticks between transactions, with junk on the ignored fields
      repeat ($urandom_range(3)) begin
        idle_t         = '0;
        idle_t.op      = 1'($urandom_range(1));
        idle_t.command = 8'($urandom_range(255));
        idle_t.sda_in  = 1'($urandom_range(1));
        send_tick(idle_t);
      end
    end
    drain();
  endtask

  // receiver: random stalls, plus one long hold-off on request so the
  // result register fills and the input side backs up
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted output transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) tracker.check_tick(out_data);
  end

  // watchdog: give up after a long run of cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    tracker       = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    hold_req      = 1'b0;
    ticks_sent    = 0;
    send_idle_pct = 9;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: command extremes, both transaction kinds, missing acks,
    // all-zero and all-one readings, go while busy and on the stop tick
    run_transfer(i2csb_pkg::OP_WRITE, 8'h00, SDA_ACKING, 0);
    run_transfer(i2csb_pkg::OP_WRITE, 8'hFF, SDA_HIGH, 0);
    run_transfer(i2csb_pkg::OP_READ, 8'h5A, SDA_LOW, 0);
    run_transfer(i2csb_pkg::OP_READ, 8'hA5, SDA_HIGH, 100);
    // address extremes
    write_address(7'h7F);
    run_transfer(i2csb_pkg::OP_WRITE, 8'h46, SDA_ACKING, 0);
    run_transfer(i2csb_pkg::OP_READ, 8'h00, SDA_RANDOM, 0);
    write_address(7'h00);
    run_transfer(i2csb_pkg::OP_READ, 8'hFF, SDA_ACKING, 100);
    run_transfer(i2csb_pkg::OP_WRITE, 8'h81, SDA_RANDOM, 0);

    // random part: slow receiver, then slow sender, then full rate with
    // one long receiver hold-off
    random_segment(9, 77, 1'b0);
    random_segment(77, 9, 1'b0);
    random_segment(0, 0, 1'b1);

    drain();
    repeat (4) @(posedge clk);
    if (tracker.faults == 0 && tracker.expected_ticks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
